/* src/bba_pkg.sv */
// shared types and constants of the bitmap block allocator
package bba_pkg;

  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned IN_USER_W  = 1;
  localparam int unsigned OUT_DATA_W = 24;
  localparam int unsigned APB_ADDR_W = 2;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [APB_ADDR_W-1:0] CFG_ADDR_NUM_BLOCKS = 2'd0;
  localparam logic [7:0]            NUM_BLOCKS_RESET    = 8'd128;

  typedef enum logic [0:0] {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NOSPACE  = 2'd1,
    STATUS_NOTFOUND = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_RECOUNT = 5'b00010,
    ST_ALLOC   = 5'b00100,
    ST_REL     = 5'b01000,
    ST_REPLY   = 5'b10000
  } state_e;

endpackage

/* src/bitmap_block_allocator.sv */
// bitmap free-block allocator with owner tags, stream request/result and apb config
//
//  channel  | dir | beat contents
//  s_axis   | in  | request: tuser operation, tdata file tag and block count
//  m_axis   | out | result: status, block valid, block index, freed count, tlast
//  apb      | in  | num_blocks register at byte address 0
//
// allocate: a used-map entry per cycle unless stalled, to min(num_blocks, BLOCK_DEPTH)
// release: one owner-tag read per cycle over all BLOCK_DEPTH entries, then the reply
// zero-block and failed allocates reply through ST_REPLY after the accept beat
// a num_blocks write in idle starts a recount over min(num_blocks, BLOCK_DEPTH) entries
// no request is taken during a recount, and a further write restarts it
// reset clears the used map and sets the free count to min(num_blocks, BLOCK_DEPTH)
// the allocate scan stalls on a free entry while the output holds a result not yet taken
module bitmap_block_allocator #(
  parameter int unsigned BLOCK_DEPTH = 128,
  parameter int unsigned MAX_REQUEST = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // file_tag [7:0], block_count [14:8]
  input  logic [bba_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // operation [0]
  input  logic [bba_pkg::IN_USER_W-1:0]    s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // status [1:0], block_valid [2], block_index [9:3], freed_count [17:10]
  output logic [bba_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                             m_axis_tlast,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bba_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [bba_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [bba_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import bba_pkg::*;

  localparam int unsigned IDX_W = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(BLOCK_DEPTH + 1);
  localparam int unsigned NB_W  = (CNT_W > 8) ? CNT_W : 8;

  state_e                 state_q, state_d;
  logic [CNT_W-1:0]       idx_q, idx_d;
  logic [CNT_W-1:0]       free_q, free_d;
  logic [7:0]             num_blocks_q, num_blocks_d;
  logic [BLOCK_DEPTH-1:0] used_q, used_d;
  logic                   pv_q;
  logic [IDX_W-1:0]       pidx_q;
  logic [7:0]             tag_q, tag_d;
  logic [6:0]             want_q, want_d;
  logic [6:0]             k_q, k_d;
  logic [7:0]             freed_q, freed_d;
  status_e                reply_q, reply_d;
  logic [7:0]             tag_mem [BLOCK_DEPTH];
  logic [7:0]             rdata_q;
  logic                   mem_we;

  logic                   out_valid_q;
  status_e                out_status_q, ld_status;
  logic                   out_bvalid_q, ld_bvalid;
  logic [6:0]             out_index_q, ld_index;
  logic [7:0]             out_freed_q, ld_freed;
  logic                   out_last_q, ld_last;
  logic                   out_load;
  logic                   out_free;

  logic                   in_fire;
  logic                   cfg_wr;
  logic [CNT_W-1:0]       act_n;
  logic [NB_W-1:0]        nb_ext;
  logic [IDX_W-1:0]       cur;
  logic                   alloc_last;
  op_e                    in_op;
  logic [7:0]             in_tag;
  logic [6:0]             in_want;

  assign in_op   = op_e'(s_axis_tuser[0]);
  assign in_tag  = s_axis_tdata[7:0];
  assign in_want = s_axis_tdata[14:8];

  assign cfg_wr        = psel && penable && pwrite && (paddr == CFG_ADDR_NUM_BLOCKS);
  assign s_axis_tready = (state_q == ST_IDLE) && !cfg_wr;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign pready        = 1'b1;
  assign prdata        = (paddr == CFG_ADDR_NUM_BLOCKS) ? APB_DATA_W'(num_blocks_q) : '0;

  assign nb_ext = NB_W'(num_blocks_q);
  assign act_n  = (nb_ext > NB_W'(BLOCK_DEPTH)) ? CNT_W'(BLOCK_DEPTH) : CNT_W'(nb_ext);
  assign cur    = idx_q[IDX_W-1:0];
  assign alloc_last = ((k_q + 7'd1) == want_q);
  assign out_free   = !out_valid_q || m_axis_tready;

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    free_d       = free_q;
    num_blocks_d = num_blocks_q;
    used_d       = used_q;
    tag_d        = tag_q;
    want_d       = want_q;
    k_d          = k_q;
    freed_d      = freed_q;
    reply_d      = reply_q;
    mem_we       = 1'b0;
    out_load     = 1'b0;
    ld_status    = STATUS_OK;
    ld_bvalid    = 1'b0;
    ld_index     = '0;
    ld_freed     = '0;
    ld_last      = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        if (cfg_wr) begin
          num_blocks_d = pwdata[7:0];
          idx_d        = '0;
          free_d       = '0;
          state_d      = ST_RECOUNT;
        end else if (in_fire) begin
          tag_d   = in_tag;
          want_d  = in_want;
          idx_d   = '0;
          k_d     = '0;
          freed_d = '0;
          if (in_op == OP_RELEASE) begin
            state_d = ST_REL;
          end else if (in_want == 7'd0) begin
            reply_d = STATUS_OK;
            state_d = ST_REPLY;
          end else if ((32'(in_want) > 32'(MAX_REQUEST)) ||
                       (32'(in_want) > 32'(free_q))) begin
            reply_d = STATUS_NOSPACE;
            state_d = ST_REPLY;
          end else begin
            state_d = ST_ALLOC;
          end
        end
      end
      ST_RECOUNT: begin
        if (cfg_wr) begin
          num_blocks_d = pwdata[7:0];
          idx_d        = '0;
          free_d       = '0;
        end else if (idx_q < act_n) begin
          if (!used_q[cur]) begin
            free_d = free_q + CNT_W'(1);
          end
          idx_d = idx_q + CNT_W'(1);
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_ALLOC: begin
        if (idx_q >= act_n) begin
          state_d = ST_IDLE;
        end else if (used_q[cur]) begin
          idx_d = idx_q + CNT_W'(1);
        end else if (out_free) begin
          used_d[cur] = 1'b1;
          mem_we      = 1'b1;
          free_d      = free_q - CNT_W'(1);
          out_load    = 1'b1;
          ld_status   = STATUS_OK;
          ld_bvalid   = 1'b1;
          ld_index    = 7'(idx_q);
          ld_last     = alloc_last;
          k_d         = k_q + 7'd1;
          idx_d       = idx_q + CNT_W'(1);
          if (alloc_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_REL: begin
        if (idx_q < CNT_W'(BLOCK_DEPTH)) begin
          idx_d = idx_q + CNT_W'(1);
        end
        if (pv_q && used_q[pidx_q] && (rdata_q == tag_q)) begin
          used_d[pidx_q] = 1'b0;
          if (CNT_W'(pidx_q) < act_n) begin
            free_d = free_q + CNT_W'(1);
          end
          if (freed_q != 8'hFF) begin
            freed_d = freed_q + 8'd1;
          end
        end
        if (!pv_q && (idx_q == CNT_W'(BLOCK_DEPTH))) begin
          reply_d = (freed_q == 8'd0) ? STATUS_NOTFOUND : STATUS_OK;
          state_d = ST_REPLY;
        end
      end
      ST_REPLY: begin
        if (out_free) begin
          out_load  = 1'b1;
          ld_status = reply_q;
          ld_freed  = freed_q;
          ld_last   = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      free_q       <= (NB_W'(NUM_BLOCKS_RESET) > NB_W'(BLOCK_DEPTH)) ?
                      CNT_W'(BLOCK_DEPTH) : CNT_W'(NUM_BLOCKS_RESET);
      num_blocks_q <= NUM_BLOCKS_RESET;
      used_q       <= '0;
      pv_q         <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      free_q       <= free_d;
      num_blocks_q <= num_blocks_d;
      used_q       <= used_d;
      pv_q         <= (state_q == ST_REL) && (idx_q < CNT_W'(BLOCK_DEPTH));
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q   <= tag_d;
    want_q  <= want_d;
    k_q     <= k_d;
    freed_q <= freed_d;
    reply_q <= reply_d;
    pidx_q  <= cur;
    if (out_load) begin
      out_status_q <= ld_status;
      out_bvalid_q <= ld_bvalid;
      out_index_q  <= ld_index;
      out_freed_q  <= ld_freed;
      out_last_q   <= ld_last;
    end
  end

  // owner tag store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tag_mem[cur] <= tag_q;
    end
    rdata_q <= tag_mem[cur];
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_freed_q, out_index_q, out_bvalid_q, out_status_q};
  assign m_axis_tlast  = out_last_q;

endmodule
